### hw/rtl/lps_pkg.sv
// lps_pkg: shared types and constants of the line pixel stepper
// no dependencies; used by the interfaces and every module of the block

package lps_pkg;

  localparam int COORD_W    = 6;
  localparam int TILE_SIZE  = 64;
  localparam int ERR_W      = COORD_W + 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_MAX = 2'd3;

  localparam logic [COORD_W-1:0] CLIP_MIN_RST = '0;
  localparam logic [COORD_W-1:0] CLIP_MAX_RST = '1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    logic   neg_x;
    logic   neg_y;
    logic   x_major;
    coord_t major;
    coord_t minor;
    logic   commit;
  } cmd_t;

  typedef struct packed {
    coord_t x_min;
    coord_t x_max;
    coord_t y_min;
    coord_t y_max;
  } clip_t;

endpackage

### hw/rtl/lps_in_if.sv
// lps_in_if: line command channel, valid/ready handshake
// depends on lps_pkg for coordinate widths

interface lps_in_if;
  logic                         valid;
  logic                         ready;
  logic [lps_pkg::COORD_W-1:0]  start_x;
  logic [lps_pkg::COORD_W-1:0]  start_y;
  logic [lps_pkg::COORD_W-1:0]  end_x;
  logic [lps_pkg::COORD_W-1:0]  end_y;
  logic                         commit;

  modport source(output valid, start_x, start_y, end_x, end_y, commit, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, commit, output ready);
endinterface

### hw/rtl/lps_out_if.sv
// lps_out_if: pixel result channel, valid/ready handshake
// depends on lps_pkg for coordinate widths

interface lps_out_if;
  logic                         valid;
  logic                         ready;
  logic [lps_pkg::COORD_W-1:0]  pixel_x;
  logic [lps_pkg::COORD_W-1:0]  pixel_y;
  logic                         inside_clip;
  logic                         write_canvas;
  logic                         last;

  modport source(output valid, pixel_x, pixel_y, inside_clip, write_canvas, last,
                 input ready);
  modport sink(input valid, pixel_x, pixel_y, inside_clip, write_canvas, last,
               output ready);
endinterface

### hw/rtl/lps_front.sv
// lps_front: takes line commands and works out direction, major axis and lengths
// depends on lps_pkg and lps_in_if; feeds lps_queue

module lps_front (
  lps_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            q_push,
  output lps_pkg::cmd_t   q_cmd
);

  logic            neg_x;
  logic            neg_y;
  lps_pkg::coord_t len_x;
  lps_pkg::coord_t len_y;
  logic            x_major;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    neg_x   = in_ch.end_x < in_ch.start_x;
    neg_y   = in_ch.end_y < in_ch.start_y;
    len_x   = neg_x ? (in_ch.start_x - in_ch.end_x) : (in_ch.end_x - in_ch.start_x);
    len_y   = neg_y ? (in_ch.start_y - in_ch.end_y) : (in_ch.end_y - in_ch.start_y);
    x_major = len_y <= len_x;

    q_cmd.start_x = in_ch.start_x;
    q_cmd.start_y = in_ch.start_y;
    q_cmd.neg_x   = neg_x;
    q_cmd.neg_y   = neg_y;
    q_cmd.x_major = x_major;
    q_cmd.major   = x_major ? len_x : len_y;
    q_cmd.minor   = x_major ? len_y : len_x;
    q_cmd.commit  = in_ch.commit;
  end

endmodule

### hw/rtl/lps_queue.sv
// lps_queue: small register queue of classified line commands
// depends on lps_pkg for the command type

module lps_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lps_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output lps_pkg::cmd_t  pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lps_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign valid   = count_r != '0;
  assign pop_cmd = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

### hw/rtl/lps_back.sv
// lps_back: Bresenham stepper, one pixel per cycle while the output is not stalled, with clip test and output register
// depends on lps_pkg and lps_out_if; fed from lps_queue

module lps_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  lps_pkg::cmd_t   q_cmd,
  output logic            q_pop,
  input  lps_pkg::clip_t  clip,
  lps_out_if.source       out_ch
);

  localparam int W  = lps_pkg::COORD_W;
  localparam int EW = lps_pkg::ERR_W;

  logic                 busy_r;
  lps_pkg::coord_t      x_r;
  lps_pkg::coord_t      y_r;
  logic signed [EW-1:0] err_r;
  lps_pkg::coord_t      cnt_r;
  logic                 neg_x_r;
  logic                 neg_y_r;
  logic                 x_major_r;
  lps_pkg::coord_t      major_r;
  lps_pkg::coord_t      minor_r;
  logic                 commit_r;

  logic                 out_valid_r;
  lps_pkg::coord_t      pix_x_r;
  lps_pkg::coord_t      pix_y_r;
  logic                 inside_r;
  logic                 write_r;
  logic                 last_r;

  logic                 adv;
  logic                 is_last;
  lps_pkg::coord_t      x_step;
  lps_pkg::coord_t      y_step;
  logic signed [EW-1:0] err_add;
  logic                 step_minor;
  lps_pkg::coord_t      x_nxt;
  lps_pkg::coord_t      y_nxt;
  logic signed [EW-1:0] err_nxt;
  logic                 pix_in_clip;

  assign adv     = busy_r && (!out_valid_r || out_ch.ready);
  assign is_last = cnt_r == '0;
  assign q_pop   = q_valid && (!busy_r || (adv && is_last));

  always_comb begin
    x_step     = neg_x_r ? (x_r - W'(1)) : (x_r + W'(1));
    y_step     = neg_y_r ? (y_r - W'(1)) : (y_r + W'(1));
    err_add    = err_r + $signed({2'b00, minor_r, 1'b0});
    step_minor = err_add > 0;
    err_nxt    = step_minor ? (err_add - $signed({2'b00, major_r, 1'b0})) : err_add;
    x_nxt      = (x_major_r || step_minor) ? x_step : x_r;
    y_nxt      = (!x_major_r || step_minor) ? y_step : y_r;

    pix_in_clip = ({1'b0, x_r} < (W + 1)'(lps_pkg::TILE_SIZE))
               && ({1'b0, y_r} < (W + 1)'(lps_pkg::TILE_SIZE))
               && (x_r >= clip.x_min) && (x_r <= clip.x_max)
               && (y_r >= clip.y_min) && (y_r <= clip.y_max);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (adv && is_last) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r       <= q_cmd.start_x;
      y_r       <= q_cmd.start_y;
      err_r     <= -$signed({3'b000, q_cmd.major});
      cnt_r     <= q_cmd.major;
      neg_x_r   <= q_cmd.neg_x;
      neg_y_r   <= q_cmd.neg_y;
      x_major_r <= q_cmd.x_major;
      major_r   <= q_cmd.major;
      minor_r   <= q_cmd.minor;
      commit_r  <= q_cmd.commit;
    end else if (adv) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_r - W'(1);
    end
    if (adv) begin
      pix_x_r  <= x_r;
      pix_y_r  <= y_r;
      inside_r <= pix_in_clip;
      write_r  <= pix_in_clip && commit_r;
      last_r   <= is_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = pix_x_r;
  assign out_ch.pixel_y      = pix_y_r;
  assign out_ch.inside_clip  = inside_r;
  assign out_ch.write_canvas = write_r;
  assign out_ch.last         = last_r;

  a_err_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (err_r <= 0))
    else $error("error term positive while stepping");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && adv && !is_last) |=> (busy_r && (cnt_r == $past(cnt_r) - W'(1))))
    else $error("pixel count did not step down");

endmodule

### hw/rtl/line_pixel_stepper.sv
// line_pixel_stepper: integer Bresenham line rasterizer for one 64x64 tile. A line command
// yields max(|dx|,|dy|)+1 pixel items, start to end, the last one marked, each with a clip
// flag from the four clip registers. The stepping registers in lps_back make one pixel per
// cycle while the output is not stalled. The first pixel passes through the queue, the
// stepping registers and the output register; commands held in the QUEUE_DEPTH-entry queue
// follow one another with no gap. Write the clip registers only while no line is in flight.
// depends on lps_pkg, lps_in_if, lps_out_if, lps_front, lps_queue and lps_back

module line_pixel_stepper #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lps_in_if.sink                          in_ch,
  lps_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lps_pkg::clip_t clip_r;
  lps_pkg::cmd_t  push_cmd;
  lps_pkg::cmd_t  pop_cmd;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r.x_min <= lps_pkg::CLIP_MIN_RST;
      clip_r.x_max <= lps_pkg::CLIP_MAX_RST;
      clip_r.y_min <= lps_pkg::CLIP_MIN_RST;
      clip_r.y_max <= lps_pkg::CLIP_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lps_pkg::REG_CLIP_X_MIN: clip_r.x_min <= cfg_data;
        lps_pkg::REG_CLIP_X_MAX: clip_r.x_max <= cfg_data;
        lps_pkg::REG_CLIP_Y_MIN: clip_r.y_min <= cfg_data;
        lps_pkg::REG_CLIP_Y_MAX: clip_r.y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  lps_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  lps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  lps_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .clip    (clip_r),
    .out_ch  (out_ch)
  );

endmodule
